[hdl/msu_pkg.sv]
// msu_pkg: shared constants and controller/datapath command and status types
// for the merge sorter unit. No dependencies.
package msu_pkg;

   localparam int DEPTH_DEF = 8;   // default store depth
   localparam int VALUE_W   = 32;  // element width, two's complement

   // controller -> datapath commands, at most one per cycle
   typedef struct packed {
      logic load;       // write item into bank 0, bump element count
      logic setup;      // set up first run pair of a pass
      logic step;       // one merge step: compare heads, write winner
      logic emit_init;  // point read address at element 0 for output
      logic out_load;   // capture read data into the output register
      logic out_next;   // output item taken: advance, clear count on last
   } msu_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic last_slot;  // next load fills the store
      logic sorted;     // run width covers whole set
      logic pass_end;   // current merge step finishes the pass
      logic out_last;   // output register holds final element
   } msu_status_type;

endpackage

[hdl/msu_dpath.sv]
// msu_dpath: element banks, merge address counters, compare and output register.
// Depends on msu_pkg.
module msu_dpath #(
   parameter int DEPTH = msu_pkg::DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  msu_pkg::msu_cmd_type        cmd,
   output msu_pkg::msu_status_type     status,
   input  logic [msu_pkg::VALUE_W-1:0] load_value,
   output logic [msu_pkg::VALUE_W-1:0] out_value,
   output logic                        out_last
);
   import msu_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // bank address
   localparam int CW = $clog2(DEPTH + 1);                // count 0..DEPTH
   localparam int SW = CW + 2;                           // bound sums

   // two ping-pong banks, each read at two addresses
   logic [VALUE_W-1:0] bank0_mem [DEPTH];
   logic [VALUE_W-1:0] bank1_mem [DEPTH];
   logic [VALUE_W-1:0] rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;

   logic [CW-1:0] n_ff, n_in;
   logic [CW:0]   w_ff, w_in;       // run width
   logic          sel_ff, sel_in;   // bank holding current runs
   logic [CW-1:0] p_ff, p_in, pend_ff, pend_in;
   logic [CW-1:0] q_ff, q_in, qend_ff, qend_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic          out_last_ff, out_last_in;

   logic [VALUE_W-1:0] head_a, head_b, win_value;
   logic          p_avail, q_avail, take_p, run_done, pass_end;
   logic [CW-1:0] p_step, q_step;
   logic [SW-1:0] lo_ext, n_ext, w_ext, mid_sum, hi_sum;
   logic [CW-1:0] run_lo, mid_nx, hi_nx;
   logic          wr_en0, wr_en1;
   logic [CW-1:0] wr_addr;
   logic [VALUE_W-1:0] wr_data;

   assign head_a  = sel_ff ? rd_a1_ff : rd_a0_ff;
   assign head_b  = sel_ff ? rd_b1_ff : rd_b0_ff;
   assign p_avail = (p_ff < pend_ff);
   assign q_avail = (q_ff < qend_ff);
   // left head wins only when strictly less; ties go right
   assign take_p  = p_avail && (!q_avail || ($signed(head_a) < $signed(head_b)));
   assign win_value = take_p ? head_a : head_b;
   assign p_step  = p_ff + CW'(take_p);
   assign q_step  = q_ff + CW'(!take_p);
   assign run_done = (p_step == pend_ff) && (q_step == qend_ff);
   assign pass_end = run_done && (qend_ff == n_ff);

   // run pair bounds starting at run_lo: mid = min(lo+w, n), hi = min(lo+2w, n)
   assign run_lo  = cmd.setup ? '0 : qend_ff;
   assign lo_ext  = SW'(run_lo);
   assign n_ext   = SW'(n_ff);
   assign w_ext   = SW'(w_ff);
   assign mid_sum = lo_ext + w_ext;
   assign hi_sum  = mid_sum + w_ext;
   assign mid_nx  = (mid_sum < n_ext) ? mid_sum[CW-1:0] : n_ff;
   assign hi_nx   = (hi_sum < n_ext) ? hi_sum[CW-1:0] : n_ff;

   always_comb begin
      n_in         = n_ff;
      w_in         = w_ff;
      sel_in       = sel_ff;
      p_in         = p_ff;
      pend_in      = pend_ff;
      q_in         = q_ff;
      qend_in      = qend_ff;
      wr_in        = wr_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      wr_en0       = 1'b0;
      wr_en1       = 1'b0;
      wr_addr      = wr_ff;
      wr_data      = win_value;
      if (cmd.load) begin
         wr_en0  = 1'b1;
         wr_addr = n_ff;
         wr_data = load_value;
         n_in    = n_ff + 1'b1;
         w_in    = (CW+1)'(1);
         sel_in  = 1'b0;
      end
      if (cmd.setup || (cmd.step && run_done && !pass_end)) begin
         p_in    = run_lo;
         pend_in = mid_nx;
         q_in    = mid_nx;
         qend_in = hi_nx;
      end
      if (cmd.setup) begin
         wr_in = '0;
      end
      if (cmd.step) begin
         wr_en0 = sel_ff;
         wr_en1 = !sel_ff;
         wr_in  = wr_ff + 1'b1;
         if (!run_done) begin
            p_in = p_step;
            q_in = q_step;
         end
         if (pass_end) begin
            sel_in = !sel_ff;
            w_in   = {w_ff[CW-1:0], 1'b0};
         end
      end
      if (cmd.emit_init) begin
         p_in = '0;
      end
      if (cmd.out_load) begin
         out_value_in = head_a;
         out_last_in  = ((p_ff + 1'b1) == n_ff);
      end
      if (cmd.out_next) begin
         p_in = p_ff + 1'b1;
         if (out_last_ff) begin
            n_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      w_ff         <= w_in;
      sel_ff       <= sel_in;
      p_ff         <= p_in;
      pend_ff      <= pend_in;
      q_ff         <= q_in;
      qend_ff      <= qend_in;
      wr_ff        <= wr_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   // bank storage: one write port, two registered read ports each
   always_ff @(posedge clock) begin
      if (wr_en0) begin
         bank0_mem[wr_addr[AW-1:0]] <= wr_data;
      end
      rd_a0_ff <= bank0_mem[p_ff[AW-1:0]];
      rd_b0_ff <= bank0_mem[q_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_en1) begin
         bank1_mem[wr_addr[AW-1:0]] <= wr_data;
      end
      rd_a1_ff <= bank1_mem[p_ff[AW-1:0]];
      rd_b1_ff <= bank1_mem[q_ff[AW-1:0]];
   end

   assign status.last_slot = (n_ff == CW'(DEPTH - 1));
   assign status.sorted    = (w_ff >= {1'b0, n_ff});
   assign status.pass_end  = pass_end;
   assign status.out_last  = out_last_ff;
   assign out_value        = out_value_ff;
   assign out_last         = out_last_ff;

endmodule

[hdl/msu_ctrl.sv]
// msu_ctrl: sequencer for load, merge passes and output of the merge sorter.
// Depends on msu_pkg.
module msu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    in_last,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   input  msu_pkg::msu_status_type status,
   output msu_pkg::msu_cmd_type    cmd
);
   import msu_pkg::*;

   localparam logic [2:0] S_LOAD = 3'd0;  // taking items
   localparam logic [2:0] S_PASS = 3'd1;  // start a pass or finish sorting
   localparam logic [2:0] S_RD   = 3'd2;  // heads being read
   localparam logic [2:0] S_MRG  = 3'd3;  // one merge step
   localparam logic [2:0] S_ERD  = 3'd4;  // output element being read
   localparam logic [2:0] S_ELD  = 3'd5;  // fill output register
   localparam logic [2:0] S_EOUT = 3'd6;  // output item offered

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         S_LOAD: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               if (in_last || status.last_slot) begin
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            if (status.sorted) begin
               cmd.emit_init = 1'b1;
               state_in      = S_ERD;
            end else begin
               cmd.setup = 1'b1;
               state_in  = S_RD;
            end
         end
         S_RD: begin
            state_in = S_MRG;
         end
         S_MRG: begin
            cmd.step = 1'b1;
            state_in = status.pass_end ? S_PASS : S_RD;
         end
         S_ERD: begin
            state_in = S_ELD;
         end
         S_ELD: begin
            cmd.out_load = 1'b1;
            state_in     = S_EOUT;
         end
         S_EOUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cmd.out_next = 1'b1;
               state_in     = status.out_last ? S_LOAD : S_ERD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/merge_sorter_unit.sv]
// merge_sorter_unit: top level of the merge sorter, collects a set of signed values
// and returns them in ascending order. Depends on msu_pkg, msu_ctrl, msu_dpath.
//
//   channel | dir | tdata                  | tlast        | tuser
//   --------+-----+------------------------+--------------+------
//   req_    | in  | [31:0] value (signed)  | is_last      | -
//   rsp_    | out | [31:0] sorted_value    | end_of_set   | -
//
// Loading takes one item per cycle. The set closes on an item with tlast
// set or on the item that fills the store.
// Sorting is bottom-up over two ping-pong banks: ceil(log2 n) passes of n merge
// steps, each a registered bank read and then a compare and write, plus a pass
// start state per pass. Output reads each item, loads it into the result register
// and then offers it on rsp_.
// Reset clears the controller and the element count; banks are not cleared.
// req_tready is low from set close until the last result is taken; rsp_ stalls
// simply hold the result register.
module merge_sorter_unit #(
   parameter int DEPTH = msu_pkg::DEPTH_DEF   // store depth, 2..64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [msu_pkg::VALUE_W-1:0] req_tdata,   // [31:0] value
   input  logic                        req_tlast,   // is_last
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [msu_pkg::VALUE_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic                        rsp_tlast    // end_of_set
);
   import msu_pkg::*;

   msu_cmd_type    cmd;
   msu_status_type status;

   // sequencer: owns handshakes, issues at most one command per cycle
   msu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_last   (req_tlast),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // banks, merge counters and output register
   msu_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .load_value (req_tdata),
      .out_value  (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

[hdl/msu_checker.sv]
// msu_checker: port-level assertions for merge_sorter_unit, attached by bind.
// Depends on msu_pkg and merge_sorter_unit.
module msu_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [msu_pkg::VALUE_W-1:0] rsp_tdata,
   input logic                        rsp_tlast
);
   import msu_pkg::*;

   // results stall cleanly: valid and item hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // input is closed while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input open during output");

   // after the final result, loading resumes at once
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("input not reopened after end of set");

   // first cycle out of reset: no result pending, input open
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind merge_sorter_unit msu_checker u_msu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
